### sv/card_deck_stream_cipher_macros.svh
// Assertion macros of the card deck cipher top level.
`ifndef CARD_DECK_STREAM_CIPHER_MACROS_SVH
`define CARD_DECK_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CDSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("card deck cipher check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define CDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("card deck cipher check failed");

`endif

### sv/cdsc_pkg.sv
// Types, constants and helper functions of the card deck stream cipher.
package cdsc_pkg;

    // Deck geometry.
    localparam int DECK_SIZE = 40;
    localparam int CARD_W    = 6;
    localparam int SUM_W     = CARD_W + 1;
    localparam int POS_W     = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
    localparam int CNT_W     = $clog2(DECK_SIZE + 1);
    localparam int HALF      = DECK_SIZE / 2;
    localparam int HALF_M1   = DECK_SIZE / 2 - 1;
    localparam int RED_DEPTH = 1 << SUM_W;

    // Function codes of an input word.
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_ENCRYPT = 2'd1;
    localparam logic [1:0] FUNC_DECRYPT = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CUT_POSITION  = 2'd0;
    localparam logic [1:0] REG_MARK_POSITION = 2'd1;
    localparam logic [1:0] REG_MARK_OFFSET   = 2'd2;

    typedef logic [CARD_W-1:0] red_tab_t [RED_DEPTH];

    // Table of x mod DECK_SIZE for every sum that the datapath can form.
    function automatic red_tab_t build_red_tab();
        red_tab_t t;
        for (int i = 0; i < RED_DEPTH; i++)
        begin
            t[i] = CARD_W'(i % DECK_SIZE);
        end
        return t;
    endfunction

    localparam red_tab_t RED_TAB = build_red_tab();

    // Reduce a value below 2*DECK_SIZE (or any 7-bit value) mod DECK_SIZE.
    function automatic logic [CARD_W-1:0] card_red(input logic [SUM_W-1:0] x);
        return RED_TAB[x];
    endfunction

    // Destination of rotated card i in the back-front interleave: even cards
    // fill the back half upward, odd cards fill the front half downward.
    function automatic logic [POS_W-1:0] shuf_dest(input logic [POS_W-1:0] i);
        logic [POS_W:0] half_i;
        half_i = {1'b0, i} >> 1;
        if (i[0])
        begin
            return POS_W'((POS_W+1)'(HALF_M1) - half_i);
        end
        return POS_W'((POS_W+1)'(HALF) + half_i);
    endfunction

endpackage

### sv/cdsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/card_deck_stream_cipher.sv
// Card deck stream cipher top level: sequencer, deck banks and configuration port.
// Input words (in_valid, in_stall, func, load_position, card_in) are taken when
// in_valid is high and in_stall is low. A load word with load_position below the
// deck size writes one deck entry and gives no output word; function code 3 is
// dropped. An encrypt or decrypt word holds in_stall high until its output word
// is registered, so no other word is taken meanwhile: one scan of the deck finds
// the mark card, a second scan finds the cut card, and a third pass copies the
// rotated and interleaved deck into the spare bank. Each pass moves one entry per
// cycle through the single read port of the deck memory. The output word appears
// on card_out with out_valid and is held while out_stall is high; the block waits
// at the end of the next cipher word until the output register is free, so no
// word is lost. Reset (rst_n low, asynchronous) restores the identity deck at once
// through per-entry valid bits and clears the three registers; no clearing pass is
// run. Registers cut_position, mark_position and mark_offset sit at byte addresses
// 0, 4 and 8 of the APB port. The user must write them only while the block is
// idle; the block itself does not enforce this.
`include "card_deck_stream_cipher_macros.svh"

module card_deck_stream_cipher (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [5:0]  load_position,
    input  logic [5:0]  card_in,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  card_out,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WAIT,
        ST_SCAN,
        ST_PAD_RD,
        ST_PAD_WAIT,
        ST_CUT_RD,
        ST_CUT_WAIT,
        ST_SHUF,
        ST_DONE
    } state_t;

    localparam int CW = cdsc_pkg::CARD_W;
    localparam int PW = cdsc_pkg::POS_W;
    localparam int NW = cdsc_pkg::CNT_W;
    localparam int SW = cdsc_pkg::SUM_W;

    // Configuration registers.
    logic [CW-1:0] cut_position_reg;
    logic [CW-1:0] mark_position_reg;
    logic [CW-1:0] mark_offset_reg;

    // Sequencer and datapath registers.
    state_t                         state_reg, state_next;
    logic [NW-1:0]                  cnt_reg, cnt_next;
    logic [PW-1:0]                  acc_reg, acc_next;
    logic [CW-1:0]                  key_reg, key_next;
    logic                           phase_reg, phase_next;
    logic                           decrypt_reg, decrypt_next;
    logic [CW-1:0]                  card_reg, card_next;
    logic [CW-1:0]                  plain_reg, plain_next;
    logic [CW-1:0]                  result_reg, result_next;
    logic [PW-1:0]                  rot_reg, rot_next;
    logic                           bank_sel_reg, bank_sel_next;
    logic [cdsc_pkg::DECK_SIZE-1:0] valid_reg, valid_next;
    logic                           rd_valid_reg, rd_valid_next;
    logic [PW-1:0]                  rd_addr_reg, rd_addr_next;
    logic                           out_valid_reg, out_valid_next;
    logic [CW-1:0]                  card_out_reg, card_out_next;

    // Deck memory signals.
    logic [PW-1:0] raddr;
    logic [PW-1:0] waddr;
    logic [CW-1:0] wdata;
    logic          we0, we1;
    logic [CW-1:0] rd0, rd1;
    logic [CW-1:0] deck_rd;

    // Helpers.
    logic          in_accept;
    logic          load_we;
    logic          shuf_we;
    logic          cnt_last;
    logic [PW-1:0] prev_idx;
    logic [PW-1:0] acc_upd;
    logic [CW-1:0] pad_r;
    logic [CW-1:0] plain_enc;
    logic [CW-1:0] result_enc;
    logic [CW-1:0] plain_dec;
    logic          cfg_we;

    // Handshake outputs.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign card_out  = card_out_reg;
    assign pready    = 1'b1;

    // Configuration writes and reads.
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_position_reg  <= '0;
            mark_position_reg <= '0;
            mark_offset_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                cdsc_pkg::REG_CUT_POSITION:  cut_position_reg  <= pwdata[CW-1:0];
                cdsc_pkg::REG_MARK_POSITION: mark_position_reg <= pwdata[CW-1:0];
                cdsc_pkg::REG_MARK_OFFSET:   mark_offset_reg   <= pwdata[CW-1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            cdsc_pkg::REG_CUT_POSITION:  prdata = 32'(cut_position_reg);
            cdsc_pkg::REG_MARK_POSITION: prdata = 32'(mark_position_reg);
            cdsc_pkg::REG_MARK_OFFSET:   prdata = 32'(mark_offset_reg);
            default:                     prdata = '0;
        endcase
    end

    // Two deck banks: the live deck is read from one, the reshuffled deck is
    // written to the other, and the roles swap at the end of each reshuffle.
    cdsc_ram #(
        .WIDTH (CW),
        .DEPTH (cdsc_pkg::DECK_SIZE)
    ) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd0)
    );

    cdsc_ram #(
        .WIDTH (CW),
        .DEPTH (cdsc_pkg::DECK_SIZE)
    ) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd1)
    );

    // An entry never written since reset reads as its own position.
    assign deck_rd = rd_valid_reg ? (bank_sel_reg ? rd1 : rd0) : CW'(rd_addr_reg);

    // Scan and reshuffle counters.
    assign cnt_last = (cnt_reg == NW'(cdsc_pkg::DECK_SIZE));
    assign prev_idx = PW'(cnt_reg - NW'(1));
    assign acc_upd  = ((cnt_reg != '0) && (deck_rd == key_reg)) ? (acc_reg | prev_idx)
                                                                : acc_reg;

    // Read address for each step of the sequencer.
    always_comb
    begin
        raddr = '0;
        unique case (state_reg)
            ST_MARK_RD: raddr = PW'(cdsc_pkg::card_red(SW'(mark_position_reg)));
            ST_SCAN:
            begin
                if (!cnt_last)
                begin
                    raddr = cnt_reg[PW-1:0];
                end
            end
            ST_PAD_RD:  raddr = PW'(cdsc_pkg::card_red(SW'(acc_reg) + SW'(1)));
            ST_CUT_RD:  raddr = PW'(cdsc_pkg::card_red(SW'(cut_position_reg)));
            ST_SHUF:
            begin
                if (!cnt_last)
                begin
                    raddr = PW'(cdsc_pkg::card_red(SW'(cnt_reg) + SW'(rot_reg)));
                end
            end
            default:    raddr = '0;
        endcase
    end

    // Deck writes: loads go to the live bank, reshuffle writes to the spare.
    assign load_we = in_accept && (func == cdsc_pkg::FUNC_LOAD)
                     && ((CW+1)'(load_position) < (CW+1)'(cdsc_pkg::DECK_SIZE));
    assign shuf_we = (state_reg == ST_SHUF) && (cnt_reg != '0);
    assign we0     = bank_sel_reg ? shuf_we : load_we;
    assign we1     = bank_sel_reg ? load_we : shuf_we;
    assign waddr   = shuf_we ? cdsc_pkg::shuf_dest(prev_idx) : load_position[PW-1:0];
    assign wdata   = shuf_we ? deck_rd : card_in;

    // Pad arithmetic.
    assign pad_r      = cdsc_pkg::card_red(SW'(deck_rd));
    assign plain_enc  = cdsc_pkg::card_red(SW'(card_reg));
    assign result_enc = cdsc_pkg::card_red(SW'(plain_enc) + SW'(pad_r));
    assign plain_dec  = cdsc_pkg::card_red(SW'(plain_enc) + SW'(cdsc_pkg::DECK_SIZE)
                                           - SW'(pad_r));

    // Sequencer next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        key_next      = key_reg;
        phase_next    = phase_reg;
        decrypt_next  = decrypt_reg;
        card_next     = card_reg;
        plain_next    = plain_reg;
        result_next   = result_reg;
        rot_next      = rot_reg;
        bank_sel_next = bank_sel_reg;
        valid_next    = valid_reg;
        rd_valid_next = valid_reg[raddr];
        rd_addr_next  = raddr;
        out_valid_next = out_valid_reg && out_stall;
        card_out_next = card_out_reg;

        if (load_we)
        begin
            valid_next[load_position[PW-1:0]] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && ((func == cdsc_pkg::FUNC_ENCRYPT)
                                  || (func == cdsc_pkg::FUNC_DECRYPT)))
                begin
                    decrypt_next = (func == cdsc_pkg::FUNC_DECRYPT);
                    card_next    = card_in;
                    state_next   = ST_MARK_RD;
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_WAIT;
            end
            ST_MARK_WAIT:
            begin
                key_next   = cdsc_pkg::card_red(SW'(cdsc_pkg::card_red(SW'(deck_rd)))
                                 + SW'(cdsc_pkg::card_red(SW'(mark_offset_reg))));
                cnt_next   = '0;
                acc_next   = '0;
                phase_next = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                acc_next = acc_upd;
                cnt_next = cnt_reg + NW'(1);
                if (cnt_last)
                begin
                    cnt_next = '0;
                    if (phase_reg)
                    begin
                        rot_next   = PW'(cdsc_pkg::card_red(SW'(acc_upd)));
                        state_next = ST_SHUF;
                    end
                    else
                    begin
                        state_next = ST_PAD_RD;
                    end
                end
            end
            ST_PAD_RD:
            begin
                state_next = ST_PAD_WAIT;
            end
            ST_PAD_WAIT:
            begin
                plain_next  = decrypt_reg ? plain_dec : plain_enc;
                result_next = decrypt_reg ? plain_dec : result_enc;
                state_next  = ST_CUT_RD;
            end
            ST_CUT_RD:
            begin
                state_next = ST_CUT_WAIT;
            end
            ST_CUT_WAIT:
            begin
                key_next   = cdsc_pkg::card_red(SW'(plain_reg)
                                 + SW'(cdsc_pkg::card_red(SW'(deck_rd))));
                cnt_next   = '0;
                acc_next   = '0;
                phase_next = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SHUF:
            begin
                cnt_next = cnt_reg + NW'(1);
                if (cnt_last)
                begin
                    cnt_next      = '0;
                    bank_sel_next = !bank_sel_reg;
                    valid_next    = '1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    card_out_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            key_reg       <= '0;
            phase_reg     <= 1'b0;
            decrypt_reg   <= 1'b0;
            card_reg      <= '0;
            plain_reg     <= '0;
            result_reg    <= '0;
            rot_reg       <= '0;
            bank_sel_reg  <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_addr_reg   <= '0;
            out_valid_reg <= 1'b0;
            card_out_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            key_reg       <= key_next;
            phase_reg     <= phase_next;
            decrypt_reg   <= decrypt_next;
            card_reg      <= card_next;
            plain_reg     <= plain_next;
            result_reg    <= result_next;
            rot_reg       <= rot_next;
            bank_sel_reg  <= bank_sel_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= rd_valid_next;
            rd_addr_reg   <= rd_addr_next;
            out_valid_reg <= out_valid_next;
            card_out_reg  <= card_out_next;
        end
    end

    // A new output word only comes out of the final sequencer step.
    `CDSC_ASSERT_NOW(a_out_from_done, clk, rst_n,
        out_valid_reg && !$past(out_valid_reg), $past(state_reg) == ST_DONE)

    // The reshuffle never writes the bank it is reading.
    `CDSC_ASSERT_NOW(a_shuf_spare_bank, clk, rst_n,
        state_reg == ST_SHUF, (bank_sel_reg ? we1 : we0) == 1'b0)

    // The end of a reshuffle swaps banks and marks the whole deck written.
    `CDSC_ASSERT_NEXT(a_shuf_swap, clk, rst_n,
        (state_reg == ST_SHUF) && cnt_last,
        (bank_sel_reg != $past(bank_sel_reg)) && (&valid_reg))

    // Every output card is a reduced card value.
    `CDSC_ASSERT_NOW(a_out_in_range, clk, rst_n,
        out_valid_reg, card_out_reg < CW'(cdsc_pkg::DECK_SIZE))

endmodule

### tb/card_deck_stream_cipher_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the card deck stream cipher against a deck model.
module card_deck_stream_cipher_test;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 140;
    localparam int LONG_HOLD     = 800;
    localparam int PHASES        = 6;
    localparam int MIXED_WORDS   = 190;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] pos;
        logic [5:0] card;
    } deck_word_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  func          = cdsc_pkg::FUNC_NONE;
    logic [5:0]  load_position = '0;
    logic [5:0]  card_in       = '0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [5:0]  card_out;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    card_deck_stream_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .load_position (load_position),
        .card_in       (card_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .card_out      (card_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // Model of the deck and of the three registers.
    logic [5:0] deck_model [cdsc_pkg::DECK_SIZE];
    logic [5:0] cut_pos_cfg;
    logic [5:0] mark_pos_cfg;
    logic [5:0] mark_off_cfg;

    // Traffic bookkeeping shared by the driver, the monitor and the sequence.
    deck_word_t  pending_words [$];
    logic [5:0]  expected_cards [$];
    deck_word_t  offered_word;
    logic [5:0]  predicted_card;
    logic [5:0]  checked_card;
    int unsigned words_pushed   = 0;
    int unsigned words_accepted = 0;
    int unsigned cards_checked  = 0;
    int unsigned settings_used  = 1;
    int unsigned mismatches     = 0;
    int unsigned send_idle_pct  = 37;
    int unsigned recv_idle_pct  = 61;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned out_hold_left  = 0;
    int unsigned quiet_cycles   = 0;

    function automatic int unsigned deck_mod(input int unsigned x);
        return x % cdsc_pkg::DECK_SIZE;
    endfunction

    // Position of a card: the OR of every position that holds it.
    function automatic int unsigned find_card(input int unsigned card);
        int unsigned acc;
        acc = 0;
        for (int i = 0; i < cdsc_pkg::DECK_SIZE; i++)
        begin
            if (deck_model[i] == card)
            begin
                acc = acc | i;
            end
        end
        return acc;
    endfunction

    // Rotate left, then deal pairs to the back half rising and the front half falling.
    function automatic void interleave_deck(input int unsigned rot);
        logic [5:0] rotated [cdsc_pkg::DECK_SIZE];
        int back;
        int front;
        back  = cdsc_pkg::DECK_SIZE / 2;
        front = cdsc_pkg::DECK_SIZE / 2 - 1;
        for (int i = 0; i < cdsc_pkg::DECK_SIZE; i++)
        begin
            rotated[i] = deck_model[deck_mod(i + deck_mod(rot))];
        end
        for (int i = 0; i < cdsc_pkg::DECK_SIZE; i += 2)
        begin
            if (back < cdsc_pkg::DECK_SIZE)
            begin
                deck_model[back] = rotated[i];
            end
            if (i + 1 < cdsc_pkg::DECK_SIZE && front >= 0 && front < cdsc_pkg::DECK_SIZE)
            begin
                deck_model[front] = rotated[i + 1];
            end
            back++;
            front--;
        end
    endfunction

    // Apply one accepted word to the model; returns 1 when it yields a card.
    function automatic bit encipher_word(input deck_word_t w, output logic [5:0] result);
        int unsigned mark;
        int unsigned pad;
        int unsigned plain;
        int unsigned cut;
        result = '0;
        if (w.func == cdsc_pkg::FUNC_LOAD)
        begin
            if (w.pos < cdsc_pkg::DECK_SIZE)
            begin
                deck_model[w.pos] = w.card;
            end
            return 1'b0;
        end
        if (w.func == cdsc_pkg::FUNC_NONE)
        begin
            return 1'b0;
        end
        mark = deck_mod(deck_mod(deck_model[deck_mod(mark_pos_cfg)]) + deck_mod(mark_off_cfg));
        pad  = deck_mod(deck_model[deck_mod(find_card(mark) + 1)]);
        if (w.func == cdsc_pkg::FUNC_ENCRYPT)
        begin
            plain  = deck_mod(w.card);
            result = 6'(deck_mod(plain + pad));
        end
        else
        begin
            plain  = deck_mod(deck_mod(w.card) + cdsc_pkg::DECK_SIZE - pad);
            result = 6'(plain);
        end
        cut = deck_mod(plain + deck_mod(deck_model[deck_mod(cut_pos_cfg)]));
        interleave_deck(find_card(cut));
        return 1'b1;
    endfunction

    // Driver: offers queued words, predicts each word as it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (encipher_word(offered_word, predicted_card))
                begin
                    expected_cards.push_back(predicted_card);
                end
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_word   = pending_words.pop_front();
                    in_valid      <= 1'b1;
                    func          <= offered_word.func;
                    load_position <= offered_word.pos;
                    card_in       <= offered_word.card;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted output word and drives the output stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_cards.size() == 0)
                begin
                    $display("%0t: card_out %0d arrived with no result expected", $time, card_out);
                    mismatches++;
                end
                else
                begin
                    checked_card = expected_cards.pop_front();
                    if (card_out !== checked_card)
                    begin
                        $display("%0t: card_out mismatch, expected %0d, actual %0d",
                                 $time, checked_card, card_out);
                        mismatches++;
                    end
                    cards_checked++;
                end
            end
            // A requested long hold-off lets the block fill up behind the output.
            if (hold_served != hold_requests)
            begin
                hold_served   = hold_requests;
                out_hold_left = LONG_HOLD;
            end
            if (out_hold_left != 0)
            begin
                out_hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_word(input logic [1:0] f, input int unsigned pos,
                             input int unsigned card);
        deck_word_t w;
        w.func = f;
        w.pos  = 6'(pos);
        w.card = 6'(card);
        pending_words.push_back(w);
        words_pushed++;
    endtask

    // Wait until every queued word is taken and every expected card has come.
    task automatic wait_drained();
        while (words_accepted != words_pushed || expected_cards.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register write over the APB port: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value & 63);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            cdsc_pkg::REG_CUT_POSITION:  cut_pos_cfg  = 6'(value);
            cdsc_pkg::REG_MARK_POSITION: mark_pos_cfg = 6'(value);
            cdsc_pkg::REG_MARK_OFFSET:   mark_off_cfg = 6'(value);
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned cut, input int unsigned mpos,
                             input int unsigned moff);
        write_reg(cdsc_pkg::REG_CUT_POSITION, cut);
        write_reg(cdsc_pkg::REG_MARK_POSITION, mpos);
        write_reg(cdsc_pkg::REG_MARK_OFFSET, moff);
        settings_used++;
    endtask

    // Load a fresh random permutation into the deck, one word per position.
    task automatic push_deck_load();
        int unsigned perm [cdsc_pkg::DECK_SIZE];
        int unsigned j;
        int unsigned t;
        for (int i = 0; i < cdsc_pkg::DECK_SIZE; i++)
        begin
            perm[i] = i;
        end
        for (int i = cdsc_pkg::DECK_SIZE - 1; i > 0; i--)
        begin
            j       = $urandom_range(i, 0);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < cdsc_pkg::DECK_SIZE; i++)
        begin
            push_word(cdsc_pkg::FUNC_LOAD, i, perm[i]);
        end
    endtask

    // Mostly cipher words on a whole deck, with stray loads and ignored words as noise.
    task automatic push_mixed(input int n);
        int unsigned r;
        int unsigned card;
        logic [1:0] f;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                push_word(cdsc_pkg::FUNC_NONE, $urandom_range(63), $urandom_range(63));
            end
            else if (r < 6)
            begin
                push_word(cdsc_pkg::FUNC_LOAD, $urandom_range(63), $urandom_range(63));
            end
            else
            begin
                f    = $urandom_range(1) ? cdsc_pkg::FUNC_ENCRYPT : cdsc_pkg::FUNC_DECRYPT;
                card = ($urandom_range(9) == 0) ? $urandom_range(63, 40) : $urandom_range(39);
                push_word(f, $urandom_range(63), card);
            end
        end
    endtask

    // Sequence: reset, directed words, then random phases under several settings.
    initial
    begin
        for (int i = 0; i < cdsc_pkg::DECK_SIZE; i++)
        begin
            deck_model[i] = 6'(i);
        end
        cut_pos_cfg  = '0;
        mark_pos_cfg = '0;
        mark_off_cfg = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words, starting from the identity deck with all registers at zero.
        push_word(cdsc_pkg::FUNC_ENCRYPT, 0, 0);
        push_word(cdsc_pkg::FUNC_ENCRYPT, 63, 39);
        push_word(cdsc_pkg::FUNC_DECRYPT, 0, 0);
        push_word(cdsc_pkg::FUNC_DECRYPT, 39, 39);
        push_word(cdsc_pkg::FUNC_ENCRYPT, 0, 63);
        push_word(cdsc_pkg::FUNC_DECRYPT, 0, 40);
        push_word(cdsc_pkg::FUNC_NONE, 63, 63);
        push_word(cdsc_pkg::FUNC_LOAD, 63, 5);
        push_word(cdsc_pkg::FUNC_LOAD, 40, 7);
        push_word(cdsc_pkg::FUNC_LOAD, 39, 39);
        push_word(cdsc_pkg::FUNC_LOAD, 0, 63);
        push_word(cdsc_pkg::FUNC_ENCRYPT, 0, 17);
        push_word(cdsc_pkg::FUNC_DECRYPT, 0, 22);
        push_word(cdsc_pkg::FUNC_LOAD, 5, 0);
        push_word(cdsc_pkg::FUNC_LOAD, 6, 0);
        push_word(cdsc_pkg::FUNC_ENCRYPT, 0, 1);
        push_word(cdsc_pkg::FUNC_DECRYPT, 0, 2);
        push_word(cdsc_pkg::FUNC_ENCRYPT, 0, 38);
        push_word(cdsc_pkg::FUNC_NONE, 0, 0);
        push_word(cdsc_pkg::FUNC_DECRYPT, 0, 63);

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (phase)
                1: configure(39, 39, 39);
                2: configure($urandom_range(39), $urandom_range(39), $urandom_range(39));
                3: configure(0, 39, 1);
                4: configure(63, 63, 63);
                5: configure($urandom_range(63), $urandom_range(63), $urandom_range(63));
                default: configure(20, 0, 39);
            endcase
            if (phase >= 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (phase >= 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 37;
            end
            push_deck_load();
            push_mixed(MIXED_WORDS / 2);
            // The output is held off for a long stretch while words keep coming.
            if (phase == 3)
            begin
                hold_requests++;
            end
            // The sender pauses until every expected card has come back.
            if (phase == 5)
            begin
                wait_drained();
            end
            push_deck_load();
            push_mixed(MIXED_WORDS - MIXED_WORDS / 2);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d accepted words and %0d checked cards under %0d settings,",
                 words_accepted, cards_checked, settings_used);
        $display("with deck loads, out-of-range cards and positions, ignored words and stalls.");
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
